// ===== sv/skti_pkg.sv =====
// Package for the sorted key table: item structs, opcode and status codes,
// field widths and default table depth. No dependencies.
package skti_pkg;

	localparam int KEY_W         = 32;
	localparam int ADDR_W        = 32;
	localparam int SLOT_W        = 8;
	localparam int TOTAL_W       = 9;
	localparam int DEPTH_DEFAULT = 256;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BAD_SLOT = 2'd2;

	localparam logic [KEY_W-1:0] TERMINAL_RESET = '1;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [KEY_W-1:0]  key;
		logic [ADDR_W-1:0] address;
		logic [SLOT_W-1:0] read_index;
	} skti_req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic [KEY_W-1:0]   key_out;
		logic [ADDR_W-1:0]  address_out;
		logic [TOTAL_W-1:0] entry_total;
		logic               was_new;
		logic [1:0]         status;
	} skti_rsp_t;

endpackage

// ===== sv/skti_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module skti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/sorted_key_table_insert.sv =====
// Top level of the sorted key table: control sequencer, entry count,
// terminal key register and output register. Uses skti_pkg and skti_ram.
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    skti_req_t
//  rsp      out        rsp_valid/rsp_ready    skti_rsp_t
//  cfg      in         cfg_valid/cfg_ready    terminal_key (32 bit)
//
// Insert: one key RAM read per cycle up to the first key not below the new
// one, then count-pos entries move up one per cycle and the new entry is
// written at pos. An equal key only updates its address; a new key on a
// full table is rejected with ST_FULL. Unused opcodes give no response.
// Reset clears the count; the RAMs are not swept. Next item accepted once
// the result is in the output register; a stalled rsp holds it, req waits.
module sorted_key_table_insert #(
	parameter int TABLE_DEPTH = skti_pkg::DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  skti_pkg::skti_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output skti_pkg::skti_rsp_t rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [31:0]         cfg_data
);
	import skti_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SCAN   = 7'b0000010,
		S_DECIDE = 7'b0000100,
		S_SHIFT  = 7'b0001000,
		S_INSERT = 7'b0010000,
		S_RDWAIT = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [KEY_W-1:0]   term_q;
	logic [KEY_W-1:0]   key_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [CNT_W-1:0]   pos_q;
	logic               eq_q;
	logic [CNT_W-1:0]   ptr_q;
	logic               vld_s1;
	logic [CNT_W-1:0]   addr_s1;
	skti_rsp_t          res_q;
	skti_rsp_t          out_q;
	logic               out_valid_q;

	logic               accept;
	logic               read_acc;
	logic               out_load;
	logic               rd_ok;
	logic               full;
	logic               issue;
	logic [CNT_W-1:0]   issue_addr;
	logic               scan_done;
	logic [CNT_W-1:0]   next_s1;

	logic               key_we, addr_we, ram_re;
	logic [IDX_W-1:0]   key_waddr, addr_waddr, ram_raddr;
	logic [KEY_W-1:0]   key_wdata, key_rdata;
	logic [ADDR_W-1:0]  addr_wdata, addr_rdata;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign read_acc  = accept && (req.opcode == OP_READ);
	assign out_load  = (state_q == S_EMIT) && (!out_valid_q || rsp_ready);
	assign cfg_ready = 1'b1;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign rd_ok = (32'(req.read_index) < 32'(count_q)) && (32'(req.read_index) < TABLE_DEPTH);
	assign full  = (count_q >= CNT_W'(TABLE_DEPTH));
	assign next_s1 = addr_s1 + CNT_W'(1);

	// scan compares the key read from addr_s1 against key_q, shift copies addr_s1 up one slot
	assign scan_done = (state_q == S_SCAN) && vld_s1 &&
		(!(key_rdata < key_q) || (next_s1 == count_q));

	always_comb begin
		issue      = 1'b0;
		issue_addr = ptr_q;
		case (state_q)
			S_SCAN: begin
				issue = (ptr_q < count_q) && !scan_done;
			end
			S_SHIFT: begin
				issue      = (ptr_q > pos_q);
				issue_addr = ptr_q - CNT_W'(1);
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	always_comb begin
		ram_re    = issue || (accept && req.opcode == OP_READ && rd_ok);
		ram_raddr = (state_q == S_IDLE) ? IDX_W'(req.read_index) : issue_addr[IDX_W-1:0];
		key_we     = 1'b0;
		addr_we    = 1'b0;
		key_waddr  = pos_q[IDX_W-1:0];
		addr_waddr = pos_q[IDX_W-1:0];
		key_wdata  = key_q;
		addr_wdata = addr_q;
		case (state_q)
			S_SHIFT: begin
				key_we     = vld_s1;
				addr_we    = vld_s1;
				key_waddr  = next_s1[IDX_W-1:0];
				addr_waddr = next_s1[IDX_W-1:0];
				key_wdata  = key_rdata;
				addr_wdata = addr_rdata;
			end
			S_INSERT: begin
				key_we  = 1'b1;
				addr_we = 1'b1;
			end
			S_DECIDE: begin
				addr_we = eq_q;
			end
			default: begin
				key_we = 1'b0;
			end
		endcase
	end

	skti_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (key_rdata)
	);

	skti_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_DEPTH)) u_addr_ram (
		.clk   (clk),
		.we    (addr_we),
		.waddr (addr_waddr),
		.wdata (addr_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (addr_rdata)
	);

	always_ff @(posedge clk) begin
		addr_s1 <= issue_addr;
		if (accept) begin
			key_q  <= (req.key == '0) ? term_q : req.key;
			addr_q <= req.address;
		end
		case (state_q)
			S_IDLE: begin
				pos_q             <= '0;
				eq_q              <= 1'b0;
				ptr_q             <= '0;
				res_q.slot        <= read_acc ? req.read_index : '0;
				res_q.key_out     <= '0;
				res_q.address_out <= '0;
				res_q.entry_total <= read_acc ? TOTAL_W'(count_q) : '0;
				res_q.was_new     <= 1'b0;
				res_q.status      <= (read_acc && !rd_ok) ? ST_BAD_SLOT : ST_OK;
			end
			S_SCAN: begin
				if (issue) begin
					ptr_q <= ptr_q + CNT_W'(1);
				end
				if (scan_done) begin
					if (key_rdata < key_q) begin
						pos_q <= count_q;
					end else begin
						pos_q <= addr_s1;
						eq_q  <= (key_rdata == key_q);
					end
				end
			end
			S_DECIDE: begin
				ptr_q             <= count_q;
				res_q.entry_total <= TOTAL_W'(count_q);
				if (eq_q) begin
					res_q.slot        <= SLOT_W'(pos_q);
					res_q.key_out     <= key_q;
					res_q.address_out <= addr_q;
				end else if (full) begin
					res_q.status <= ST_FULL;
				end
			end
			S_SHIFT: begin
				if (issue) begin
					ptr_q <= issue_addr;
				end
			end
			S_INSERT: begin
				res_q.slot        <= SLOT_W'(pos_q);
				res_q.key_out     <= key_q;
				res_q.address_out <= addr_q;
				res_q.entry_total <= TOTAL_W'(count_q + CNT_W'(1));
				res_q.was_new     <= 1'b1;
			end
			S_RDWAIT: begin
				if (res_q.status == ST_OK) begin
					res_q.key_out     <= key_rdata;
					res_q.address_out <= addr_rdata;
				end else begin
					res_q.slot <= '0;
				end
			end
			default: begin
				eq_q <= eq_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			term_q      <= TERMINAL_RESET;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			vld_s1 <= issue;
			if (cfg_valid && cfg_ready) begin
				term_q <= cfg_data;
			end
			if (out_load) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (rsp_valid && rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.opcode)
							OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_EMIT;
							end
							OP_INSERT: begin
								state_q <= (count_q == '0) ? S_DECIDE : S_SCAN;
							end
							OP_READ: begin
								state_q <= S_RDWAIT;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= (eq_q || full) ? S_EMIT : S_SHIFT;
				end
				S_SHIFT: begin
					if (!issue) begin
						state_q <= S_INSERT;
					end
				end
				S_INSERT: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_EMIT;
				end
				S_RDWAIT: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !(key_we || addr_we))
		else $error("RAM write while idle");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INSERT) |-> (pos_q <= count_q) && !full)
		else $error("insert without room or past the count");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.opcode == OP_CLEAR) |=> (count_q == '0))
		else $error("clear did not empty the table");

endmodule
